### hdl/huffman_code_builder_core_defines.svh
// Assertion macros for the port checker of the code builder.
`ifndef HUFFMAN_CODE_BUILDER_CORE_DEFINES_SVH
`define HUFFMAN_CODE_BUILDER_CORE_DEFINES_SVH
// Asserts that an antecedent implies a consequent in the same cycle.
`define HCB_ASSERT_IMPLY(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication failed");
// Asserts that an antecedent implies a consequent in the next cycle.
`define HCB_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle implication failed");
`endif

### hdl/hcb_pkg.sv
// Package with shared widths and types of the code builder.
package hcb_pkg;
  localparam int WEIGHT_W = 16;
  localparam int SUM_W = 21;
  localparam int CODE_W = 31;
  localparam int IDX_W = 5;
  localparam int LEN_W = 5;
  localparam int NODE_W = 6;

  // One node memory word.
  typedef struct packed {
    logic [SUM_W-1:0]  weight;
    logic              has_parent;
    logic [NODE_W-1:0] parent;
    logic              is_right;
  } node_t;
endpackage

### hdl/hcb_node_ram.sv
// Node memory: one write port, one registered read port.
module hcb_node_ram #(
  parameter int DEPTH = 63
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [hcb_pkg::NODE_W-1:0]  waddr,
  input  hcb_pkg::node_t              wdata,
  input  logic [hcb_pkg::NODE_W-1:0]  raddr,
  output hcb_pkg::node_t              rdata
);
  import hcb_pkg::*;

  node_t mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/huffman_code_builder_core.sv
// Top level of the Huffman code builder.
// Leaf weights enter on the in_ channel, one transaction per leaf; in_tuser
// marks the final leaf. Leaves past LEAVES are dropped, but a final mark on
// one still starts construction. After the final leaf the block clears
// the parent links of the leaves, then performs n-1 merges. Each
// merge scans the parentless nodes through the one read port of the node
// memory, then writes the two children and the new node in the states
// S_WLO, S_WHI and S_WNEW. Codes are then emitted, one leaf at a
// time, by walking parent links to the root: one memory read per node on
// the path. Building is quadratic in the leaf count. Input is not accepted
// from the final leaf until the last code has entered the output register.
// The result sits in an output register; when out_tready is low the walk
// waits. Reset returns to loading with no leaves held; the memory needs no
// clearing pass.
module huffman_code_builder_core #(
  parameter int LEAVES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // leaf_weight[15:0]
  input  logic        in_tuser,   // last_leaf
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // leaf_index[4:0], code_bits[35:5], code_length[40:36]
  output logic        out_tlast   // last_code
);
  import hcb_pkg::*;

  localparam int NODES = 2 * LEAVES - 1;

  typedef enum logic [3:0] {
    S_LOAD, S_CLR, S_SCAN, S_SCAN_END, S_WLO, S_WHI, S_WNEW,
    S_EM_START, S_EM_STEP, S_EM_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [NODE_W-1:0] cnt_r, cnt_nxt;        // leaf count
  logic [NODE_W-1:0] i_r, i_nxt;            // new node / clear index
  logic [NODE_W-1:0] k_r, k_nxt;            // scan address
  logic              kv_r, kv_nxt;          // read data valid for k_r-1
  logic [NODE_W-1:0] kd_r, kd_nxt;          // node index of read data
  logic              h1_r, h1_nxt, h2_r, h2_nxt;
  logic [SUM_W-1:0]  w1_r, w1_nxt, w2_r, w2_nxt;
  logic [NODE_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [NODE_W-1:0] leaf_r, leaf_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              ov_r, ov_nxt;
  logic [47:0]       od_r, od_nxt;
  logic              ol_r, ol_nxt;

  logic              we;
  logic [NODE_W-1:0] waddr, raddr;
  node_t             wdata, rdata;

  hcb_node_ram #(.DEPTH(NODES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign in_tready = (state_r == S_LOAD);
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tlast = ol_r;

  // Sequencer for loading, merging and code walking.
  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; i_nxt = i_r; k_nxt = k_r;
    kv_nxt = 1'b0; kd_nxt = k_r;
    h1_nxt = h1_r; h2_nxt = h2_r; w1_nxt = w1_r; w2_nxt = w2_r;
    lo_nxt = lo_r; hi_nxt = hi_r; leaf_nxt = leaf_r;
    code_nxt = code_r; len_nxt = len_r;
    ov_nxt = ov_r; od_nxt = od_r; ol_nxt = ol_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = k_r;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          if (32'(cnt_r) < LEAVES) begin
            we = 1'b1; waddr = cnt_r;
            wdata.weight = SUM_W'(in_tdata);
            cnt_nxt = cnt_r + 1'b1;
          end
          if (in_tuser) begin
            state_nxt = S_CLR; i_nxt = '0;
          end
        end
      end
      S_CLR: begin
        // Read-modify-write would be needed; instead rewrite via read.
        raddr = i_r;
        kv_nxt = 1'b1; kd_nxt = i_r;
        if (kv_r) begin
          we = 1'b1; waddr = kd_r;
          wdata.weight = rdata.weight;
        end
        if (i_r == cnt_r) begin
          state_nxt = (cnt_r == NODE_W'(1)) ? S_EM_START : S_SCAN;
          kv_nxt = 1'b0;
          i_nxt = cnt_r; k_nxt = '0; h1_nxt = 1'b0; h2_nxt = 1'b0;
          leaf_nxt = '0;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_SCAN, S_SCAN_END: begin
        if (state_r == S_SCAN) begin
          raddr = k_r; kv_nxt = 1'b1; kd_nxt = k_r;
          k_nxt = k_r + 1'b1;
          if (k_r + 1'b1 == i_r) state_nxt = S_SCAN_END;
        end else begin
          state_nxt = S_WLO;
        end
        if (kv_r && !rdata.has_parent) begin
          if (!h1_r || rdata.weight < w1_r) begin
            if (h1_r) begin
              h2_nxt = 1'b1; w2_nxt = w1_r; hi_nxt = lo_r;
            end
            h1_nxt = 1'b1; w1_nxt = rdata.weight; lo_nxt = kd_r;
          end else if (!h2_r || rdata.weight < w2_r) begin
            h2_nxt = 1'b1; w2_nxt = rdata.weight; hi_nxt = kd_r;
          end
        end
      end
      S_WLO: begin
        we = 1'b1; waddr = lo_r;
        wdata.weight = w1_r; wdata.has_parent = 1'b1;
        wdata.parent = i_r; wdata.is_right = 1'b0;
        state_nxt = S_WHI;
      end
      S_WHI: begin
        we = 1'b1; waddr = hi_r;
        wdata.weight = w2_r; wdata.has_parent = 1'b1;
        wdata.parent = i_r; wdata.is_right = 1'b1;
        state_nxt = S_WNEW;
      end
      S_WNEW: begin
        we = 1'b1; waddr = i_r;
        wdata.weight = w1_r + w2_r;
        if (i_r + 1'b1 == {cnt_r[NODE_W-2:0], 1'b0} - 1'b1) begin
          state_nxt = S_EM_START; leaf_nxt = '0;
        end else begin
          state_nxt = S_SCAN; i_nxt = i_r + 1'b1; k_nxt = '0;
          h1_nxt = 1'b0; h2_nxt = 1'b0;
        end
      end
      S_EM_START: begin
        raddr = leaf_r; code_nxt = '0; len_nxt = '0;
        state_nxt = S_EM_STEP;
      end
      S_EM_STEP: begin
        // The read issued in the previous cycle is the current node.
        if (rdata.has_parent && len_r != LEN_W'(CODE_W)) begin
          code_nxt = code_r | (CODE_W'(rdata.is_right) << len_r);
          len_nxt = len_r + 1'b1;
          raddr = rdata.parent;
          state_nxt = S_EM_STEP;
        end else begin
          state_nxt = S_EM_OUT;
        end
      end
      S_EM_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = {7'd0, len_r, code_r, leaf_r[IDX_W-1:0]};
          ol_nxt = (leaf_r + 1'b1 == cnt_r);
          if (leaf_r + 1'b1 == cnt_r) begin
            state_nxt = S_LOAD; cnt_nxt = '0;
          end else begin
            leaf_nxt = leaf_r + 1'b1; state_nxt = S_EM_START;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; ov_r <= 1'b0; kv_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt; kv_r <= kv_nxt;
    end
    i_r <= i_nxt; k_r <= k_nxt; kd_r <= kd_nxt;
    h1_r <= h1_nxt; h2_r <= h2_nxt; w1_r <= w1_nxt; w2_r <= w2_nxt;
    lo_r <= lo_nxt; hi_r <= hi_nxt; leaf_r <= leaf_nxt;
    code_r <= code_nxt; len_r <= len_nxt; od_r <= od_nxt; ol_r <= ol_nxt;
  end
endmodule

### hdl/hcb_checker.sv
// Port checker for the code builder, bound to the top level.
`include "huffman_code_builder_core_defines.svh"
module hcb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast
);
  // A stalled result holds.
  `HCB_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // Input is never taken while a result other than the last code is offered.
  `HCB_ASSERT_IMPLY(a_excl, clk, rst_n, out_tvalid && !out_tlast, !in_tready)
  // Padding bits stay zero.
  `HCB_ASSERT_IMPLY(a_pad, clk, rst_n, out_tvalid, out_tdata[47:41] == 7'd0)
  // After the final code is taken no further result follows at once.
  `HCB_ASSERT_NEXT(a_end, clk, rst_n, out_tvalid && out_tready && out_tlast, !out_tvalid)
endmodule

bind huffman_code_builder_core hcb_checker u_hcb_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast)
);

### bench/huffman_code_checker.sv
// Checker that predicts Huffman codes from accepted leaves and compares the results.
`timescale 1ns / 100ps

module huffman_code_checker #(
  parameter int LEAVES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        out_tlast,
  output int          error_count,
  output int          codes_pending
);
  import hcb_pkg::*;

  localparam int NODES = 2 * LEAVES - 1;

  // One expected code word.
  typedef struct packed {
    logic [IDX_W-1:0]  leaf_index;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              last_code;
  } leaf_code_t;

  logic [SUM_W-1:0]  tree_weight [NODES];
  logic              tree_linked [NODES];
  logic [NODE_W-1:0] tree_parent [NODES];
  logic              tree_right  [NODES];
  int                leaves_held;
  leaf_code_t        expected_codes[$];

  assign codes_pending = expected_codes.size();

  // Build the tree from the held leaves and queue one code per leaf.
  task automatic build_codes();
    int n;
    int lo;
    int hi;
    bit have_lo;
    bit have_hi;
    int c;
    leaf_code_t code;
    n = leaves_held;
    for (int k = 0; k < NODES; k++) begin
      tree_linked[k] = 1'b0;
      tree_right[k] = 1'b0;
    end
    for (int i = n; i + 1 < 2 * n; i++) begin
      have_lo = 0;
      have_hi = 0;
      lo = 0;
      hi = 0;
      for (int k = 0; k < i; k++) begin
        if (tree_linked[k]) continue;
        if (!have_lo || tree_weight[k] < tree_weight[lo]) begin
          if (have_lo) begin
            have_hi = 1;
            hi = lo;
          end
          have_lo = 1;
          lo = k;
        end else if (!have_hi || tree_weight[k] < tree_weight[hi]) begin
          have_hi = 1;
          hi = k;
        end
      end
      tree_linked[lo] = 1'b1;
      tree_parent[lo] = NODE_W'(i);
      tree_right[lo] = 1'b0;
      tree_linked[hi] = 1'b1;
      tree_parent[hi] = NODE_W'(i);
      tree_right[hi] = 1'b1;
      tree_weight[i] = tree_weight[lo] + tree_weight[hi];
    end
    // Walk each leaf up to the root; the first step is the lowest code bit.
    for (int i = 0; i < n; i++) begin
      code = '0;
      code.leaf_index = IDX_W'(i);
      c = i;
      while (tree_linked[c] && code.code_length < 31) begin
        code.code_bits[code.code_length] = tree_right[c];
        code.code_length++;
        c = tree_parent[c];
      end
      code.last_code = (i + 1 == n);
      expected_codes.push_back(code);
    end
    leaves_held = 0;
  endtask

  // Track leaves and compare every result transaction.
  always @(posedge clk) begin
    leaf_code_t seen;
    leaf_code_t want;
    if (!rst_n) begin
      leaves_held = 0;
      error_count <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (leaves_held < LEAVES) begin
          tree_weight[leaves_held] = SUM_W'(in_tdata);
          leaves_held = leaves_held + 1;
        end
        if (in_tuser) build_codes();
      end
      if (out_tvalid && out_tready) begin
        seen = {out_tdata[4:0], out_tdata[35:5], out_tdata[40:36], out_tlast};
        if (expected_codes.size() == 0) begin
          if (error_count < 10) $display("Unexpected code result %h", seen);
          error_count <= error_count + 1;
        end else begin
          want = expected_codes.pop_front();
          if (seen !== want || out_tdata[47:41] !== '0) begin
            if (error_count < 10)
              $display("Code mismatch: exp %0d %h %0d %0d, got %0d %h %0d %0d",
                       want.leaf_index, want.code_bits, want.code_length, want.last_code,
                       seen.leaf_index, seen.code_bits, seen.code_length, seen.last_code);
            error_count <= error_count + 1;
          end
        end
      end
    end
  end
endmodule

### bench/huffman_code_builder_core_tb.sv
// Testbench top: drives leaf runs into the code builder and gives the verdict.
`timescale 1ns / 100ps

module huffman_code_builder_core_tb;
  localparam int LEAVES = 32;
  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;
  int          error_count;
  int          codes_pending;
  int          idle_cycles;
  bit          steady;
  int          leaves_sent;

  huffman_code_builder_core #(.LEAVES(LEAVES)) dut (.*);

  huffman_code_checker #(.LEAVES(LEAVES)) checker_i (.*);

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result-side stalls, suppressed during the steady stretch.
  initial out_tready <= 1'b0;
  always @(posedge clk) out_tready <= steady || ($urandom_range(99) >= 38);

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one leaf and wait until it is accepted, with random gaps before it.
  // The valid stays high after acceptance; the caller drops it when idle.
  task automatic send_leaf(input logic [15:0] weight, input logic last);
    while (!steady && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= weight;
    in_tuser <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    leaves_sent++;
  endtask

  // Random weight: mostly spread, sometimes extreme or tied.
  function automatic logic [15:0] pick_weight();
    case ($urandom_range(3))
      0: return 16'($urandom_range(3));
      1: return 16'hFFFF - 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_run(input int count);
    for (int i = 0; i < count; i++) send_leaf(pick_weight(), i == count - 1);
  endtask

  initial begin
    int count;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    steady = 1'b0;
    leaves_sent = 0;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single leaf, zero and maximal pairs, equal weights.
    send_leaf(16'h0000, 1'b1);
    send_leaf(16'hFFFF, 1'b1);
    send_leaf(16'hFFFF, 1'b0);
    send_leaf(16'hFFFF, 1'b1);
    send_leaf(16'h0000, 1'b0);
    send_leaf(16'h0000, 1'b1);
    for (int i = 0; i < 4; i++) send_leaf(16'd7, i == 3);
    // Skewed weights give a deep code.
    for (int i = 0; i < 10; i++) send_leaf(16'(1 << i), i == 9);

    // Pause until every code has arrived.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (codes_pending != 0) @(posedge clk);

    // Overflow: 35 leaves, the last three dropped, mark on a dropped leaf.
    for (int i = 0; i < 35; i++) send_leaf(16'($urandom), i == 34);

    // Random runs, with a steady stretch in the middle.
    while (leaves_sent < 470) begin
      steady = (leaves_sent > 200 && leaves_sent < 280);
      count = ($urandom_range(9) == 0) ? $urandom_range(LEAVES, LEAVES + 3)
                                        : $urandom_range(1, 12);
      send_run(count);
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (codes_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0 && codes_pending == 0)
      $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
